### src/ths_pkg.sv
// ----------------------------------------------------------------------------
// ths_pkg - shared types and constants for the terrain height sampler
// Word layouts, grid store geometry, datapath step codes and the
// controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package ths_pkg;

	// Grid store geometry
	localparam int MAX_COLUMNS = 256;
	localparam int MAX_ROWS    = 256;
	localparam int COL_W       = $clog2(MAX_COLUMNS);
	localparam int ROW_W       = $clog2(MAX_ROWS);
	localparam int DEPTH       = MAX_COLUMNS * MAX_ROWS;
	localparam int ADDR_W      = $clog2(DEPTH);

	// Configuration port
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 31;
	localparam int CNT_W       = 9;
	localparam logic [CFG_INDEX_W-1:0] CFG_GRID_COLUMNS    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_GRID_ROWS       = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_POINT_SPACING   = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_INVERSE_SPACING = 2'd3;

	// Item modes
	localparam logic [1:0] MODE_WRITE  = 2'd0;
	localparam logic [1:0] MODE_READ   = 2'd1;
	localparam logic [1:0] MODE_SAMPLE = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// Datapath widths
	localparam int AX_W   = 42;             // offset position, Q.17
	localparam int MB_W   = 17;             // narrow multiplier operand, sign bit zero
	localparam int PROD_W = AX_W + MB_W;
	localparam int SUM_W  = PROD_W + 15;    // hi product shifted by 16 plus lo product
	localparam int S_W    = SUM_W - 17;     // scaled coordinate, Q.16
	localparam int U_W    = S_W - 17;       // integer part without sign
	localparam int ACC_W  = 51;
	localparam int H_W    = 36;

	localparam logic signed [31:0] HEIGHT_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] HEIGHT_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic [1:0]         mode;
		logic [7:0]         column_index;
		logic [7:0]         row_index;
		logic signed [31:0] height_value;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_z;
	} ths_item_t;

	typedef struct packed {
		logic signed [31:0] height_out;
		logic               inside_grid;
	} ths_result_t;

	// One datapath step per cycle
	typedef enum logic [4:0] {
		OP_NOP,
		OP_CLEAR,
		OP_WRITE,
		OP_READ,
		OP_READ_OUT,
		OP_INVALID,
		OP_EXT_X,
		OP_EXT_Z,
		OP_X_HI,
		OP_X_LO,
		OP_Z_HI,
		OP_Z_LO,
		OP_S_Z,
		OP_RD00,
		OP_RD10,
		OP_RD01,
		OP_RD11,
		OP_MUL_U,
		OP_MUL_V,
		OP_SUM,
		OP_OUT
	} ths_op_t;

	typedef struct packed {
		logic    load;
		ths_op_t op;
	} ths_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic in_grid;
	} ths_status_t;

	// Linear store address of a grid point
	function automatic logic [ADDR_W-1:0] store_addr(input logic [15:0] row,
			input logic [15:0] col);
		return ADDR_W'(32'(row) * 32'(MAX_COLUMNS) + 32'(col));
	endfunction

endpackage

### src/terrain_height_sampler_top.sv
// ----------------------------------------------------------------------------
// terrain_height_sampler_top - terrain height grid with triangle sampling
// Holds a grid of Q16.16 heights; writes, reads back and samples it.
// ----------------------------------------------------------------------------
// After reset the block clears its 65536-entry height store, one entry per
// cycle, and holds busy high for the whole sweep; configuration writes are
// taken at any time. An item is taken when start is high and busy is low, and
// its result word shows on result for one cycle with done high; done cannot be
// held off, so it must be captured in that cycle. A sample outside the grid
// stops after its first corner read. busy drops in the done cycle, so the next
// item may start there. Sample time is set by the single shared 42x17
// multiplier (two extents, two partial products per axis, two interpolation
// products) and by the one store read port, which fetches the four cell
// corners one after another.
module terrain_height_sampler_top
	import ths_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  ths_item_t              item,
	output logic                   done,
	output ths_result_t            result,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	ths_cmd_t    cmd;
	ths_status_t status;

	// Sequencer
	ths_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (item.mode),
		.status (status),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Store and arithmetic
	ths_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

	// A result word only appears once the block is free again
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// An accepted item makes the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("item accepted but block not busy");

	// One result per item: strobes never come back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done strobe held for two cycles");

	// No load step is issued while a sequence is running
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!busy && start))
		else $error("item load while busy");

endmodule

### src/ths_ctrl.sv
// ----------------------------------------------------------------------------
// ths_ctrl - sequencer for the terrain height sampler
// Runs the store clearing sweep after reset, takes items and steps the
// datapath through write, read or sample sequences.
// ----------------------------------------------------------------------------
module ths_ctrl
	import ths_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [1:0]  mode,
	input  ths_status_t status,
	output logic        busy,
	output logic        done,
	output ths_cmd_t    cmd
);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_WRITE,
		ST_READ,
		ST_READ_OUT,
		ST_INVALID,
		ST_EXT_X,
		ST_EXT_Z,
		ST_X_HI,
		ST_X_LO,
		ST_Z_HI,
		ST_Z_LO,
		ST_S_Z,
		ST_RD00,
		ST_RD10,
		ST_RD01,
		ST_RD11,
		ST_MUL_U,
		ST_MUL_V,
		ST_SUM,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	// State and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
		end else begin
			// strobe in the cycle after a result step
			done_q <= (state_q == ST_WRITE) || (state_q == ST_READ_OUT) ||
				(state_q == ST_INVALID) || (state_q == ST_OUT);
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						busy_q <= 1'b1;
						unique case (mode)
							MODE_WRITE:  state_q <= ST_WRITE;
							MODE_READ:   state_q <= ST_READ;
							MODE_SAMPLE: state_q <= ST_EXT_X;
							MODE_UNUSED: state_q <= ST_INVALID;
						endcase
					end
				end
				ST_CLEAR: begin
					if (status.clr_last) begin
						state_q <= ST_IDLE;
						busy_q  <= 1'b0;
					end
				end
				ST_READ:  state_q <= ST_READ_OUT;
				ST_EXT_X: state_q <= ST_EXT_Z;
				ST_EXT_Z: state_q <= ST_X_HI;
				ST_X_HI:  state_q <= ST_X_LO;
				ST_X_LO:  state_q <= ST_Z_HI;
				ST_Z_HI:  state_q <= ST_Z_LO;
				ST_Z_LO:  state_q <= ST_S_Z;
				ST_S_Z:   state_q <= ST_RD00;
				ST_RD00:  state_q <= status.in_grid ? ST_RD10 : ST_INVALID;
				ST_RD10:  state_q <= ST_RD01;
				ST_RD01:  state_q <= ST_RD11;
				ST_RD11:  state_q <= ST_MUL_U;
				ST_MUL_U: state_q <= ST_MUL_V;
				ST_MUL_V: state_q <= ST_SUM;
				ST_SUM:   state_q <= ST_OUT;
				// result steps: the word is out after this edge
				ST_WRITE, ST_READ_OUT, ST_INVALID, ST_OUT: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	// Step code for the datapath
	always_comb begin
		cmd.load = (state_q == ST_IDLE) && start;
		unique case (state_q)
			ST_IDLE:     cmd.op = OP_NOP;
			ST_CLEAR:    cmd.op = OP_CLEAR;
			ST_WRITE:    cmd.op = OP_WRITE;
			ST_READ:     cmd.op = OP_READ;
			ST_READ_OUT: cmd.op = OP_READ_OUT;
			ST_INVALID:  cmd.op = OP_INVALID;
			ST_EXT_X:    cmd.op = OP_EXT_X;
			ST_EXT_Z:    cmd.op = OP_EXT_Z;
			ST_X_HI:     cmd.op = OP_X_HI;
			ST_X_LO:     cmd.op = OP_X_LO;
			ST_Z_HI:     cmd.op = OP_Z_HI;
			ST_Z_LO:     cmd.op = OP_Z_LO;
			ST_S_Z:      cmd.op = OP_S_Z;
			ST_RD00:     cmd.op = OP_RD00;
			ST_RD10:     cmd.op = OP_RD10;
			ST_RD01:     cmd.op = OP_RD01;
			ST_RD11:     cmd.op = OP_RD11;
			ST_MUL_U:    cmd.op = OP_MUL_U;
			ST_MUL_V:    cmd.op = OP_MUL_V;
			ST_SUM:      cmd.op = OP_SUM;
			ST_OUT:      cmd.op = OP_OUT;
		endcase
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

### src/ths_datapath.sv
// ----------------------------------------------------------------------------
// ths_datapath - height store, configuration registers and sample math
// One shared multiplier, one store read port, and the registers that hold
// the scaled coordinates, the four corner heights and the accumulator.
// ----------------------------------------------------------------------------
module ths_datapath
	import ths_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  ths_item_t              item,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  ths_cmd_t               cmd,
	output ths_status_t            status,
	output ths_result_t            result
);

	// Configuration registers
	logic [CNT_W-1:0]      cols_q;
	logic [CNT_W-1:0]      rows_q;
	logic [CFG_DATA_W-1:0] spacing_q;
	logic [CFG_DATA_W-1:0] inv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q    <= CNT_W'(256);
			rows_q    <= CNT_W'(256);
			spacing_q <= CFG_DATA_W'(65536);
			inv_q     <= CFG_DATA_W'(65536);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GRID_COLUMNS:    cols_q    <= cfg_data[CNT_W-1:0];
				CFG_GRID_ROWS:       rows_q    <= cfg_data[CNT_W-1:0];
				CFG_POINT_SPACING:   spacing_q <= cfg_data;
				CFG_INVERSE_SPACING: inv_q     <= cfg_data;
			endcase
		end
	end

	// Grid size in use, saturated to the store
	logic [CNT_W-1:0] cols_eff;
	logic [CNT_W-1:0] rows_eff;
	logic [CNT_W-1:0] cols_m1;
	logic [CNT_W-1:0] rows_m1;

	assign cols_eff = (32'(cols_q) > 32'(MAX_COLUMNS)) ? CNT_W'(MAX_COLUMNS) : cols_q;
	assign rows_eff = (32'(rows_q) > 32'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : rows_q;
	assign cols_m1  = cols_eff - CNT_W'(1);
	assign rows_m1  = rows_eff - CNT_W'(1);

	// Item word, held for the whole sequence
	ths_item_t item_q;
	logic      in_store;
	logic [ADDR_W-1:0] item_addr;

	always_ff @(posedge clk) begin
		if (cmd.load)
			item_q <= item;
	end

	assign in_store  = (16'(item_q.column_index) < 16'(MAX_COLUMNS)) &&
		(16'(item_q.row_index) < 16'(MAX_ROWS));
	assign item_addr = store_addr(16'(item_q.row_index), 16'(item_q.column_index));

	// Sweep counter for the clearing pass
	logic [ADDR_W-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_q <= '0;
		else if (cmd.op == OP_CLEAR)
			clr_q <= clr_q + ADDR_W'(1);
	end

	assign status.clr_last = (clr_q == ADDR_W'(DEPTH - 1));

	// Scaled coordinates and cell selection
	logic signed [AX_W-1:0]  axx_q;
	logic signed [AX_W-1:0]  axz_q;
	logic signed [PROD_W-1:0] ahi_q;
	logic signed [S_W-1:0]   sx_q;
	logic signed [S_W-1:0]   sz_q;
	logic signed [SUM_W-1:0] s_sum;
	logic signed [S_W-1:0]   s_next;
	logic [15:0]             fu;
	logic [15:0]             fv;
	logic                    upper;
	logic [COL_W-1:0]        u0;
	logic [COL_W-1:0]        u1;
	logic [ROW_W-1:0]        v0;
	logic [ROW_W-1:0]        v1;
	logic signed [PROD_W-1:0] prod_q;

	// floor((hi * 2^16 + lo) / 2^17)
	assign s_sum  = (SUM_W'(ahi_q) <<< 16) + SUM_W'(prod_q);
	assign s_next = S_W'(s_sum >>> 17);

	assign fu    = sx_q[15:0];
	assign fv    = sz_q[15:0];
	assign upper = fu > fv;
	assign u0    = sx_q[16 +: COL_W];
	assign v0    = sz_q[16 +: ROW_W];
	assign u1    = u0 + COL_W'(1);
	assign v1    = v0 + ROW_W'(1);

	assign status.in_grid = (cols_eff >= CNT_W'(2)) && (rows_eff >= CNT_W'(2)) &&
		!sx_q[S_W-1] && !sz_q[S_W-1] &&
		(sx_q[S_W-2:16] < U_W'(cols_m1)) && (sz_q[S_W-2:16] < U_W'(rows_m1));

	// Height store: clearing sweep, item writes, one registered read
	logic [31:0]       height_mem [DEPTH];
	logic [31:0]       rd_q;
	logic              mem_we;
	logic              mem_re;
	logic [ADDR_W-1:0] wr_addr;
	logic [31:0]       wr_data;
	logic [ADDR_W-1:0] rd_addr;

	assign mem_we  = (cmd.op == OP_CLEAR) || ((cmd.op == OP_WRITE) && in_store);
	assign wr_addr = (cmd.op == OP_CLEAR) ? clr_q : item_addr;
	assign wr_data = (cmd.op == OP_CLEAR) ? 32'd0 : item_q.height_value;

	always_comb begin
		mem_re  = 1'b1;
		rd_addr = item_addr;
		unique case (cmd.op)
			OP_READ: rd_addr = item_addr;
			OP_RD00: rd_addr = store_addr(16'(v0), 16'(u0));
			OP_RD10: rd_addr = store_addr(16'(v0), 16'(u1));
			OP_RD01: rd_addr = store_addr(16'(v1), 16'(u0));
			OP_RD11: rd_addr = store_addr(16'(v1), 16'(u1));
			default: mem_re = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			height_mem[wr_addr] <= wr_data;
		if (mem_re)
			rd_q <= height_mem[rd_addr];
	end

	// Corner heights; the last corner stays in the read register
	logic signed [31:0] p00_q;
	logic signed [31:0] p10_q;
	logic signed [31:0] p01_q;
	logic signed [31:0] p11;
	logic signed [32:0] du;
	logic signed [32:0] dv;

	assign p11 = rd_q;
	assign du  = upper ? (33'(p10_q) - 33'(p00_q)) : (33'(p11) - 33'(p01_q));
	assign dv  = upper ? (33'(p11) - 33'(p10_q)) : (33'(p01_q) - 33'(p00_q));

	// Shared multiplier operand select
	logic signed [AX_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_EXT_X: begin
				mul_a = AX_W'(spacing_q);
				mul_b = MB_W'(cols_m1);
			end
			OP_EXT_Z: begin
				mul_a = AX_W'(spacing_q);
				mul_b = MB_W'(rows_m1);
			end
			OP_X_HI: begin
				mul_a = axx_q;
				mul_b = MB_W'(inv_q[CFG_DATA_W-1:16]);
			end
			OP_X_LO: begin
				mul_a = axx_q;
				mul_b = MB_W'(inv_q[15:0]);
			end
			OP_Z_HI: begin
				mul_a = axz_q;
				mul_b = MB_W'(inv_q[CFG_DATA_W-1:16]);
			end
			OP_Z_LO: begin
				mul_a = axz_q;
				mul_b = MB_W'(inv_q[15:0]);
			end
			OP_MUL_U: begin
				mul_a = AX_W'(du);
				mul_b = MB_W'(fu);
			end
			OP_MUL_V: begin
				mul_a = AX_W'(dv);
				mul_b = MB_W'(fv);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// Sequence registers, loaded by step
	logic signed [ACC_W-1:0] accu_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [H_W-1:0]   h_sum;
	logic signed [31:0]      h_sat;

	assign h_sum = H_W'(p00_q) + H_W'(acc_q >>> 16);
	always_comb begin
		if (h_sum > H_W'(HEIGHT_MAX))
			h_sat = HEIGHT_MAX;
		else if (h_sum < H_W'(HEIGHT_MIN))
			h_sat = HEIGHT_MIN;
		else
			h_sat = h_sum[31:0];
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_EXT_Z: axx_q <= (AX_W'(item_q.pos_x) <<< 1) + AX_W'(prod_q);
			OP_X_HI:  axz_q <= (AX_W'(item_q.pos_z) <<< 1) + AX_W'(prod_q);
			OP_X_LO:  ahi_q <= prod_q;
			OP_Z_HI:  sx_q  <= s_next;
			OP_Z_LO:  ahi_q <= prod_q;
			OP_S_Z:   sz_q  <= s_next;
			OP_RD10:  p00_q <= rd_q;
			OP_RD01:  p10_q <= rd_q;
			OP_RD11:  p01_q <= rd_q;
			OP_MUL_V: accu_q <= ACC_W'(prod_q);
			// round half up before the final shift
			OP_SUM:   acc_q <= accu_q + ACC_W'(prod_q) + ACC_W'(32768);
			default: ;
		endcase
	end

	// Result word
	ths_result_t res_q;

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_WRITE: begin
				res_q.height_out  <= item_q.height_value;
				res_q.inside_grid <= in_store;
			end
			OP_READ_OUT: begin
				res_q.height_out  <= in_store ? rd_q : 32'd0;
				res_q.inside_grid <= in_store;
			end
			OP_INVALID: begin
				res_q.height_out  <= HEIGHT_MIN;
				res_q.inside_grid <= 1'b0;
			end
			OP_OUT: begin
				res_q.height_out  <= h_sat;
				res_q.inside_grid <= 1'b1;
			end
			default: ;
		endcase
	end

	assign result = res_q;

endmodule
